// ===== rtl/core/lkv_pkg.sv =====
// Shared field widths, codes and result type of the linear key/value table.
package lkv_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    function automatic int lkv_aw(input int capacity);
        return (capacity > 1) ? $clog2(capacity) : 1;
    endfunction

    function automatic int lkv_dw(input int key_width, input int value_width);
        return ((key_width < KEY_W) ? key_width : KEY_W)
             + ((value_width < VALUE_W) ? value_width : VALUE_W);
    endfunction

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_ACCESS = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic                 found;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   read_value;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
    } t_result;

endpackage

// ===== rtl/core/lkv_mem.sv =====
// Entry memory holding one key and value per row, one write and one registered read port.
module lkv_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lkv_ctrl.sv =====
// Sequencer that searches, appends and compacts the entry memory and forms each result.
module lkv_ctrl
    import lkv_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [OPCODE_W-1:0]                  i_opcode,
    input  logic [KEY_W-1:0]                     i_key,
    input  logic [VALUE_W-1:0]                   i_value,
    output logic                                 o_busy,
    output logic                                 o_res_valid,
    output t_result                              o_res,
    input  logic                                 i_res_ready,
    output logic                                 o_mem_re,
    output logic [lkv_aw(CAPACITY)-1:0]          o_mem_raddr,
    output logic                                 o_mem_we,
    output logic [lkv_aw(CAPACITY)-1:0]          o_mem_waddr,
    output logic [lkv_dw(KEY_WIDTH, VALUE_WIDTH)-1:0] o_mem_wdata,
    input  logic [lkv_dw(KEY_WIDTH, VALUE_WIDTH)-1:0] i_mem_rdata
);

    localparam int KS_W = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int VS_W = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [OPCODE_W-1:0]   r_op, n_op;
    logic [KS_W-1:0]       r_key, n_key;
    logic [VS_W-1:0]       r_val, n_val;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ra, n_ra;
    logic [AW-1:0]         r_ca, n_ca;
    logic                  r_cv, n_cv;
    logic                  r_hit, n_hit;
    t_status               r_status, n_status;
    logic [AW-1:0]         r_index, n_index;
    logic [VS_W-1:0]       r_rdv, n_rdv;

    logic [KS_W-1:0]       rd_key;
    logic [VS_W-1:0]       rd_val;
    logic                  match;
    logic                  full;
    logic                  more;
    logic [CW-1:0]         pos1;
    logic [AW+INDEX_W-1:0] idx_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;
    logic [VS_W+VALUE_W-1:0] rdv_ext;

    assign rd_key = i_mem_rdata[KS_W+VS_W-1:VS_W];
    assign rd_val = i_mem_rdata[VS_W-1:0];
    assign match  = r_cv && (rd_key == r_key);
    assign full   = (r_count >= CW'(CAPACITY));
    assign more   = (r_ra < r_count);
    assign pos1   = CW'(r_ca) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_count     = r_count;
        n_ra        = r_ra;
        n_ca        = r_ca;
        n_cv        = r_cv;
        n_hit       = r_hit;
        n_status    = r_status;
        n_index     = r_index;
        n_rdv       = r_rdv;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ra[AW-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[AW-1:0];
        o_mem_wdata = {r_key, r_val};
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_key   = i_key[KS_W-1:0];
                    n_val   = i_value[VS_W-1:0];
                    n_ra    = '0;
                    n_cv    = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (match || (!r_cv && !more)) begin
                    n_hit    = match;
                    n_status = ST_OK;
                    n_index  = '0;
                    n_rdv    = '0;
                    n_cv     = 1'b0;
                    n_state  = S_DONE;
                    case (r_op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_index  = r_count[AW-1:0];
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (!match) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_index = r_ca;
                                if (pos1 < r_count) begin
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = pos1[AW-1:0];
                                    n_ca        = pos1[AW-1:0];
                                    n_cv        = 1'b1;
                                    n_ra        = pos1 + CW'(1);
                                    n_state     = S_SHIFT;
                                end else begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (!match) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_index = r_ca;
                                n_rdv   = rd_val;
                            end
                        end
                        OP_ACCESS: begin
                            if (match) begin
                                n_index = r_ca;
                                n_rdv   = rd_val;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = {r_key, {VS_W{1'b0}}};
                                n_index     = r_count[AW-1:0];
                                n_count     = r_count + CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (more) begin
                    o_mem_re = 1'b1;
                    n_ca     = r_ra[AW-1:0];
                    n_cv     = 1'b1;
                    n_ra     = r_ra + CW'(1);
                end else begin
                    n_cv = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_cv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_ca - AW'(1);
                    o_mem_wdata = i_mem_rdata;
                end
                if (more) begin
                    o_mem_re = 1'b1;
                    n_ca     = r_ra[AW-1:0];
                    n_cv     = 1'b1;
                    n_ra     = r_ra + CW'(1);
                end else begin
                    n_cv = 1'b0;
                end
                if (!r_cv) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cv    <= n_cv;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_ra     <= n_ra;
        r_ca     <= n_ca;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_index  <= n_index;
        r_rdv    <= n_rdv;
    end

    assign idx_ext = {{INDEX_W{1'b0}}, r_index};
    assign cnt_ext = {{COUNT_W{1'b0}}, r_count};
    assign rdv_ext = {{VALUE_W{1'b0}}, r_rdv};

    assign o_busy              = (r_state != S_IDLE);
    assign o_res.status        = r_status;
    assign o_res.found         = r_hit;
    assign o_res.index         = idx_ext[INDEX_W-1:0];
    assign o_res.read_value    = rdv_ext[VALUE_W-1:0];
    assign o_res.count         = cnt_ext[COUNT_W-1:0];
    assign o_res.is_empty      = (r_count == '0);

endmodule

// ===== rtl/core/linear_key_value_table.sv =====
// Top level of the linear key/value table: sequencer, entry memory and result register.
//
//  Channel  Direction  Handshake           Beat fields
//  input    in         i_valid / o_stall   i_opcode, i_key, i_value
//  result   out        o_valid / i_stall   o_status, o_found, o_index, o_read_value,
//                                          o_count, o_is_empty
//
// For every item, erase included, the search reads one row per cycle over the single read
// port and stops at the first match, and an erase carries the compaction on from there, so
// every row is still read only once.
// Reset clears the entry count and the sequencer; stored rows need no clearing pass.
// A finished result waits in the output register while the next item is taken in; while
// a held result blocks the following one, the sequencer stays busy and stalls the input.
module linear_key_value_table
    import lkv_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [INDEX_W-1:0]  o_index,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_empty
);

    localparam int KS_W = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int VS_W = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW   = KS_W + VS_W;

    logic          busy;
    logic          res_valid;
    t_result       res;
    logic          out_free;
    logic          r_ov;
    t_result       r_out;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] mem_rdata;

    lkv_ctrl #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (out_free),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    lkv_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_stall      = busy;
    assign o_valid      = r_ov;
    assign o_status     = r_out.status;
    assign o_found      = r_out.found;
    assign o_index      = r_out.index;
    assign o_read_value = r_out.read_value;
    assign o_count      = r_out.count;
    assign o_is_empty   = r_out.is_empty;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Sequencer did not go busy after taking a beat.");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOT_FOUND) |-> (!o_found && o_index == '0
            && o_read_value == '0))
        else $error("Not-found result carries a match, an index or a value.");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_index == '0 && o_read_value == '0
            && !o_is_empty))
        else $error("Full result carries an index or a value, or claims empty.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_count == '0 && o_status != ST_FULL))
        else $error("Empty result with a non-zero count or a full status.");

endmodule

// ===== test/tb_linear_key_value_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the linear key/value table, checked against a predictor.
module tb_linear_key_value_table;
    import lkv_pkg::*;

    localparam int TABLE_DEPTH     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 60;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } t_request;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic [KEY_W-1:0]    i_key = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic                o_found;
    logic [INDEX_W-1:0]  o_index;
    logic [VALUE_W-1:0]  o_read_value;
    logic [COUNT_W-1:0]  o_count;
    logic                o_is_empty;

    t_request          request_queue[$];
    t_result           expected_results[$];
    logic [KEY_W-1:0]   model_keys[TABLE_DEPTH];
    logic [VALUE_W-1:0] model_values[TABLE_DEPTH];
    int unsigned        model_count = 0;
    int unsigned        planned_items = 0;
    int unsigned        error_count = 0;
    int unsigned        idle_pct = 40;

    t_request    send_req;
    int unsigned send_gap = 0;

    t_result     expected_res;
    int unsigned stall_left = 0;
    int unsigned stall_gap;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    bit          hold_done = 1'b0;

    int unsigned idle_cycles = 0;
    int unsigned cycle_count = 0;

    linear_key_value_table i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_index      (o_index),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result table_step(input t_request req);
        t_result     res;
        logic        hit;
        int unsigned pos;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        pos = 0;
        for (int unsigned i = 0; i < model_count; i++) begin
            if (!hit && model_keys[i] == req.key) begin
                hit = 1'b1;
                pos = i;
            end
        end
        case (req.opcode)
            OP_CLEAR: begin
                model_count = 0;
            end
            OP_INSERT: begin
                if (model_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    res.index = INDEX_W'(model_count);
                    model_keys[model_count] = req.key;
                    model_values[model_count] = req.value;
                    model_count++;
                end
            end
            OP_ERASE: begin
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.index = INDEX_W'(pos);
                    for (int unsigned j = pos; j + 1 < model_count; j++) begin
                        model_keys[j] = model_keys[j + 1];
                        model_values[j] = model_values[j + 1];
                    end
                    model_count--;
                end
            end
            OP_LOOKUP: begin
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.index = INDEX_W'(pos);
                    res.read_value = model_values[pos];
                end
            end
            OP_ACCESS: begin
                if (hit) begin
                    res.index = INDEX_W'(pos);
                    res.read_value = model_values[pos];
                end else if (model_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    res.index = INDEX_W'(model_count);
                    model_keys[model_count] = req.key;
                    model_values[model_count] = '0;
                    model_count++;
                end
            end
            default: begin
            end
        endcase
        res.found = hit;
        res.count = COUNT_W'(model_count);
        res.is_empty = (model_count == 0);
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h0000_0001;
            3: return 32'h0000_0002;
            4: return 32'h8000_0000;
            5: return 32'h7FFF_FFFF;
            6: return 32'hA5A5_A5A5;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return OP_INSERT;
        if (roll < 50) return OP_ERASE;
        if (roll < 72) return OP_LOOKUP;
        if (roll < 90) return OP_ACCESS;
        if (roll < 93) return OP_CLEAR;
        return OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    task automatic add_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value);
        t_request req;
        req.opcode = op;
        req.key = key;
        req.value = value;
        request_queue.push_back(req);
        if (op <= OP_ACCESS) begin
            planned_items++;
        end
    endtask

    // Fills the table to capacity, then tries to grow it further and works on the full table.
    task automatic add_fill_sequence();
        add_request(OP_CLEAR, $urandom, $urandom);
        repeat (TABLE_DEPTH) add_request(OP_INSERT, pool_key(), $urandom);
        add_request(OP_INSERT, pool_key(), $urandom);
        add_request(OP_ACCESS, $urandom_range(16, 32'h7FFF_FFF0), $urandom);
        repeat ($urandom_range(2, 8)) add_request(pick_op(), pool_key(), $urandom);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_results.push_back(table_step(send_req));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                send_req = request_queue.pop_front();
                i_opcode <= send_req.opcode;
                i_key <= send_req.key;
                i_value <= send_req.value;
                i_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with no expectation waiting", $time);
                    error_count++;
                end else begin
                    expected_res = expected_results.pop_front();
                    check_field("status", 32'(expected_res.status), 32'(o_status));
                    check_field("found", 32'(expected_res.found), 32'(o_found));
                    check_field("index", 32'(expected_res.index), 32'(o_index));
                    check_field("read_value", expected_res.read_value, o_read_value);
                    check_field("count", 32'(expected_res.count), 32'(o_count));
                    check_field("is_empty", 32'(expected_res.is_empty), 32'(o_is_empty));
                end
            end
            // One long hold-off lets the table back up until it stalls the input beats.
            if (!hold_done && results_seen == HOLD_OFF_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_OFF_CYCLES;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_gap = pick_gap();
                if (stall_gap > 0) begin
                    stall_left <= stall_gap - 1;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) begin
            idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 60);
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        add_request(OP_CLEAR, '0, '0);
        add_request(OP_LOOKUP, 32'h1234_5678, '0);
        add_request(OP_ERASE, 32'h1234_5678, '1);
        add_request(OP_ACCESS, '1, 32'h5A5A_5A5A);
        add_request(OP_INSERT, '0, '1);
        add_request(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        add_request(OP_INSERT, '0, 32'h0000_0001);
        add_request(OP_LOOKUP, '0, '0);
        add_request(OP_ACCESS, '0, 32'hDEAD_BEEF);
        add_request(OP_LOOKUP, '1, '0);
        add_request(OP_ERASE, '0, '0);
        add_request(OP_LOOKUP, '0, '0);
        add_request(OP_LOOKUP, 32'hAAAA_AAAA, '0);
        add_request(OP_UNUSED_LO, $urandom, $urandom);
        add_request(OP_UNUSED_LO + 3'd1, $urandom, $urandom);
        add_request(OP_UNUSED_HI, $urandom, $urandom);
        add_request(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        add_request(OP_ERASE, 32'h5555_5555, '0);
        add_request(OP_CLEAR, '1, '1);
        add_request(OP_LOOKUP, '0, '0);
        add_request(OP_ACCESS, 32'h8000_0000, '1);

        add_fill_sequence();
        while (planned_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    add_fill_sequence();
                end
                5, 6, 7: begin
                    repeat ($urandom_range(1, 4)) add_request(OPCODE_W'($urandom_range(0, 7)),
                                                              $urandom, $urandom);
                end
                default: begin
                    repeat ($urandom_range(8, 24)) add_request(pick_op(), pool_key(), $urandom);
                end
            endcase
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lkv_pkg.sv
rtl/core/lkv_mem.sv
rtl/core/lkv_ctrl.sv
rtl/core/linear_key_value_table.sv
test/tb_linear_key_value_table.sv
